### rtl/lge_pkg.sv
// Shared definitions for the life grid engine: command codes, rule constants
// and the packing of the stream words.
// No dependencies; every other file of the block but lge_ram imports this package.
package lge_pkg;

  // Command codes carried in the action field.
  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_GEN   = 3'd2;
  localparam logic [2:0] ACT_SHIFT = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  // Neighbour counts of the B3/S23 rule.
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  // Field widths and word widths of the two streams.
  localparam int ACTION_W   = 3;
  localparam int COORD_W    = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [COORD_W-1:0]  coord_t;

endpackage

### rtl/lge_ram.sv
// Generic simple dual-port RAM: one write port and one read port with a
// registered read. No dependencies.
module lge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/lge_life_row.sv
// Next-generation value of one grid row from that row and the rows above and below it.
// Depends on lge_pkg for the rule constants.
module lge_life_row #(
  parameter int GRID_WIDTH = 32
) (
  input  logic [GRID_WIDTH-1:0] above,
  input  logic [GRID_WIDTH-1:0] centre,
  input  logic [GRID_WIDTH-1:0] below,
  output logic [GRID_WIDTH-1:0] next_row
);
  import lge_pkg::*;

  // The edge columns stay frozen.
  assign next_row[0]            = centre[0];
  assign next_row[GRID_WIDTH-1] = centre[GRID_WIDTH-1];

  // Each interior cell counts its eight neighbours and applies the rule.
  for (genvar c = 1; c < GRID_WIDTH - 1; c++) begin : g_col
    logic [3:0] count;
    assign count = 4'(above[c-1]) + 4'(above[c]) + 4'(above[c+1])
                 + 4'(centre[c-1]) + 4'(centre[c+1])
                 + 4'(below[c-1]) + 4'(below[c]) + 4'(below[c+1]);
    assign next_row[c] = (count == BIRTH_COUNT) || (centre[c] && count == KEEP_COUNT);
  end

endmodule

### rtl/life_grid_engine_unit.sv
// Life grid engine: cell write, cell read, generation, shift down and clear.
// A write or read passes S_CELL_RD, S_CELL_MOD and S_FIN; a generation or shift
// down walks the rows in S_WALK before S_FIN; clear and unused codes go to S_FIN.
// One command at a time; the walks move one row per cycle through the single
// read port of the grid RAM. Reset clears every row-valid bit, so the grid
// reads dead at once; clear does the same.
module life_grid_engine_unit #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // Fields from bit 0: action[2:0], col[7:3], row[12:8], cell_in[13], zero.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lge_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: cell_out[0], done_action[3:1], zero.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lge_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import lge_pkg::*;

  localparam int RW = $clog2(GRID_HEIGHT);
  localparam logic [6:0]    WIDTH_LIM  = 7'(GRID_WIDTH);
  localparam logic [8:0]    HEIGHT_LIM = 9'(GRID_HEIGHT);
  localparam logic [RW-1:0] LAST_ROW   = RW'(GRID_HEIGHT - 1);
  localparam logic [RW-1:0] SHIFT_TOP  = RW'(GRID_HEIGHT - 2);
  localparam logic [RW-1:0] ROW_ONE    = RW'(1);
  localparam logic [RW-1:0] ROW_TWO    = RW'(2);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CELL_RD  = 3'd1;
  localparam logic [2:0] S_CELL_MOD = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_FIN      = 3'd4;

  logic [2:0]            state;
  action_t               cmd_action;
  coord_t                cmd_col;
  coord_t                cmd_row;
  logic                  cmd_cell;
  logic                  res_cell;
  logic [GRID_HEIGHT-1:0] row_valid;

  logic [RW-1:0]         rd_ptr;
  logic                  rd_more;
  logic                  pend;
  logic [RW-1:0]         q_addr;
  logic                  rd_hit;
  logic [GRID_WIDTH-1:0] win_a;
  logic [GRID_WIDTH-1:0] win_b;

  logic                  out_cell;
  action_t               out_action;

  logic                  accept;
  logic                  rd_en;
  logic [RW-1:0]         rd_addr;
  logic [GRID_WIDTH-1:0] rd_data;
  logic [GRID_WIDTH-1:0] row_q;
  logic                  wr_en;
  logic [RW-1:0]         wr_addr;
  logic [GRID_WIDTH-1:0] wr_data;
  logic [GRID_WIDTH-1:0] life_row;
  logic [GRID_WIDTH-1:0] cell_mask;
  logic [GRID_WIDTH-1:0] cell_shifted;
  logic                  col_ok;
  logic                  row_ok;
  logic                  is_gen;
  logic                  walk_done;
  logic                  out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // A row that was never written since reset or clear reads as dead.
  assign row_q        = rd_hit ? rd_data : '0;
  assign col_ok       = 7'(cmd_col) < WIDTH_LIM;
  assign row_ok       = 9'(cmd_row) < HEIGHT_LIM;
  assign cell_mask    = GRID_WIDTH'(1) << cmd_col;
  assign cell_shifted = row_q >> cmd_col;
  assign is_gen       = (cmd_action == ACT_GEN);
  assign walk_done    = !rd_more && !pend;

  lge_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The window holds the two rows above the one arriving from the RAM.
  lge_life_row #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_life (
    .above    (win_a),
    .centre   (win_b),
    .below    (row_q),
    .next_row (life_row)
  );

  // RAM port control for the cell access and the row walks.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_ptr;
    wr_en   = 1'b0;
    wr_addr = q_addr;
    wr_data = row_q;
    case (state)
      S_CELL_RD: begin
        rd_en   = 1'b1;
        rd_addr = RW'(cmd_row);
      end
      S_CELL_MOD: begin
        wr_en   = (cmd_action == ACT_WRITE) && col_ok && row_ok;
        wr_addr = RW'(cmd_row);
        wr_data = cmd_cell ? (row_q | cell_mask) : (row_q & ~cell_mask);
      end
      S_WALK: begin
        rd_en = rd_more;
        if (is_gen) begin
          // Row q_addr has arrived, so row q_addr-1 can be rewritten.
          wr_en   = pend && (q_addr >= ROW_TWO);
          wr_addr = q_addr - ROW_ONE;
          wr_data = life_row;
        end else begin
          wr_en   = pend;
          wr_addr = q_addr + ROW_ONE;
          wr_data = row_q & ~GRID_WIDTH'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Row-valid bits stand in for the reset value of the grid.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (accept && s_axis_tdata[ACTION_W-1:0] == ACT_CLEAR) begin
      row_valid <= '0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (state == S_WALK && !is_gen && walk_done) begin
        row_valid[0] <= 1'b0;
        row_valid[1] <= 1'b0;
      end
    end
  end

  // Read-hit flag is registered alongside the RAM read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hit <= row_valid[rd_addr];
    end
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_more <= 1'b0;
      pend    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (s_axis_tdata[ACTION_W-1:0])
              ACT_WRITE, ACT_READ: state <= S_CELL_RD;
              ACT_GEN: begin
                state   <= S_WALK;
                rd_more <= 1'b1;
              end
              ACT_SHIFT: begin
                state   <= S_WALK;
                rd_more <= 1'b1;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_CELL_RD: state <= S_CELL_MOD;
        S_CELL_MOD: state <= S_FIN;
        S_WALK: begin
          pend <= rd_more;
          if (rd_more) begin
            if ((is_gen && rd_ptr == LAST_ROW) || (!is_gen && rd_ptr == ROW_ONE)) begin
              rd_more <= 1'b0;
            end
          end
          if (walk_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command word, walk pointers, row window and read result.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_action <= s_axis_tdata[ACTION_W-1:0];
      cmd_col    <= s_axis_tdata[ACTION_W +: COORD_W];
      cmd_row    <= s_axis_tdata[ACTION_W + COORD_W +: COORD_W];
      cmd_cell   <= s_axis_tdata[ACTION_W + 2 * COORD_W];
      res_cell   <= 1'b0;
      rd_ptr     <= (s_axis_tdata[ACTION_W-1:0] == ACT_GEN) ? '0 : SHIFT_TOP;
    end else begin
      if (state == S_CELL_MOD && cmd_action == ACT_READ) begin
        res_cell <= col_ok && row_ok && cell_shifted[0];
      end
      if (state == S_WALK) begin
        if (rd_more) begin
          q_addr <= rd_ptr;
          rd_ptr <= is_gen ? rd_ptr + ROW_ONE : rd_ptr - ROW_ONE;
        end
        if (pend) begin
          win_a <= win_b;
          win_b <= row_q;
        end
      end
    end
  end

  // Output register: the result word waits here until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_cell   <= res_cell;
      out_action <= cmd_action;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W - 1 - ACTION_W)'(0), out_action, out_cell};

`ifndef SYNTHESIS
  // Reads and writes of a walk never meet on the same row.
  assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("grid read and write collide on one row");

  // A generation never rewrites the top or bottom row.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && is_gen && wr_en) |-> (wr_addr != '0 && wr_addr != LAST_ROW))
    else $error("generation wrote a frozen border row");

  // The grid is written only by a cell write or a walk.
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CELL_MOD || state == S_WALK))
    else $error("grid written outside a command");

  // A finished command waits while the output word is still held.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && m_axis_tvalid && !m_axis_tready) |=> (state == S_FIN))
    else $error("result overwrote a pending output word");
`endif

endmodule

### test/life_grid_checker.sv
// Checker for the life grid engine: watches both stream channels, keeps its own copy
// of the grid, predicts each result word and compares it with what the block returns.
// Depends on lge_pkg for the command codes, rule counts and word widths.
`timescale 1ns / 1ps

module life_grid_checker #(
  parameter int GRID_W = 32,
  parameter int GRID_H = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // Fields from bit 0: action, col, row, cell_in, zero.
  input  logic [lge_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: cell_out, done_action, zero.
  input  logic [lge_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int                              fail_count,
  output int                              results_owed,
  output int                              gen_count,
  output int                              live_reads
);
  import lge_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic    cell_val;
    action_t act;
  } result_t;

  // Our own copy of the grid; bit c of row r is the cell at column c, row r.
  logic [GRID_W-1:0] grid_cells [GRID_H];
  result_t           owed_results [$];

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // One generation of the B3/S23 rule; every count comes from the old grid and the
  // border ring stays as it is.
  function automatic void evolve_grid();
    logic [GRID_W-1:0] prior [GRID_H];
    int nb;
    prior = grid_cells;
    for (int r = 1; r < GRID_H - 1; r++) begin
      for (int c = 1; c < GRID_W - 1; c++) begin
        nb = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) nb += prior[r + dr][c + dc];
        grid_cells[r][c] = (nb == BIRTH_COUNT) || (prior[r][c] && nb == KEEP_COUNT);
      end
    end
  endfunction

  // Rows move down by one with column 0 killed; the two top rows end up dead.
  function automatic void shift_grid_down();
    for (int r = GRID_H - 1; r >= 2; r--) begin
      grid_cells[r]    = grid_cells[r - 1];
      grid_cells[r][0] = 1'b0;
    end
    grid_cells[0] = '0;
    grid_cells[1] = '0;
  endfunction

  function automatic result_t apply_command(input action_t act, input coord_t col,
                                            input coord_t row, input logic val);
    result_t res;
    res.cell_val = 1'b0;
    res.act      = act;
    case (act)
      ACT_WRITE: begin
        if (col < GRID_W && row < GRID_H) grid_cells[row][col] = val;
      end
      ACT_READ: begin
        if (col < GRID_W && row < GRID_H) res.cell_val = grid_cells[row][col];
      end
      ACT_GEN: begin
        evolve_grid();
      end
      ACT_SHIFT: begin
        shift_grid_down();
      end
      ACT_CLEAR: begin
        for (int r = 0; r < GRID_H; r++) grid_cells[r] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Results are checked before the command accepted on the same edge is predicted.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      for (int r = 0; r < GRID_H; r++) grid_cells[r] = '0;
      owed_results.delete();
      results_owed = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cell_val = m_axis_tdata[0];
        got.act      = m_axis_tdata[3:1];
        if (owed_results.size() == 0) begin
          report($sformatf("result word %h arrived with nothing expected", m_axis_tdata));
        end else begin
          want = owed_results.pop_front();
          if (got.cell_val !== want.cell_val)
            report($sformatf("cell_out %b, expected %b (action %0d)", got.cell_val,
                             want.cell_val, want.act));
          if (got.act !== want.act)
            report($sformatf("done_action %0d, expected %0d", got.act, want.act));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_command(s_axis_tdata[2:0], s_axis_tdata[7:3], s_axis_tdata[12:8],
                             s_axis_tdata[13]);
        if (want.act == ACT_GEN) gen_count++;
        if (want.act == ACT_READ && want.cell_val) live_reads++;
        owed_results.push_back(want);
      end
      results_owed = owed_results.size();
    end
  end

  initial begin
    fail_count   = 0;
    results_owed = 0;
    gen_count    = 0;
    live_reads   = 0;
  end

endmodule

### test/tb.sv
// Top of the life grid engine testbench: clock, reset, command stimulus and the verdict.
// Depends on lge_pkg, life_grid_engine_unit and life_grid_checker.
`timescale 1ns / 1ps

module tb;
  import lge_pkg::*;

  localparam int          ITEMS        = 1000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          SETTLE       = 40;
  localparam action_t     ACT_SPARE_LO = 3'd5;
  localparam action_t     ACT_SPARE_HI = 3'd7;
  localparam logic [31:0] MAX_COORD    = 31;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int   fail_count;
  int   results_owed;
  int   gen_count;
  int   live_reads;
  int   words_sent = 0;
  logic src_idle = 1'b1;
  logic snk_idle = 1'b1;
  logic hold_req = 1'b0;

  always #5 clk = ~clk;

  life_grid_engine_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  life_grid_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .results_owed  (results_owed),
    .gen_count     (gen_count),
    .live_reads    (live_reads)
  );

  // Offers one command word and waits until it is taken; valid stays high afterwards
  // so that back-to-back words need no second assignment in one step.
  task automatic send_cmd(input action_t act, input coord_t col, input coord_t row,
                          input logic val);
    @(negedge clk);
    if (src_idle && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, val, row, col, act};
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  // Stops offering and waits until every predicted result has been returned.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  function automatic coord_t near(input int base);
    return coord_t'(base + $urandom_range(7));
  endfunction

  // The receiver: random back-pressure, and one long hold when asked for.
  initial begin
    int held;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end
      m_axis_tready <= !(snk_idle && $urandom_range(99) < 20);
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int phase;
    int base_c;
    int base_r;
    int last_sent;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: corners, a blinker, frozen border, shift, write of a dead cell,
    // the spare codes and clear.
    send_cmd(ACT_WRITE, 0, 0, 1'b1);
    send_cmd(ACT_WRITE, 31, 31, 1'b1);
    send_cmd(ACT_WRITE, 31, 0, 1'b1);
    send_cmd(ACT_WRITE, 0, 31, 1'b1);
    send_cmd(ACT_WRITE, 10, 5, 1'b1);
    send_cmd(ACT_WRITE, 11, 5, 1'b1);
    send_cmd(ACT_WRITE, 12, 5, 1'b1);
    send_cmd(ACT_GEN, 0, 0, 1'b0);
    send_cmd(ACT_READ, 11, 4, 1'b0);
    send_cmd(ACT_READ, 10, 5, 1'b0);
    send_cmd(ACT_READ, 0, 0, 1'b0);
    send_cmd(ACT_SHIFT, 31, 31, 1'b1);
    send_cmd(ACT_READ, 11, 5, 1'b0);
    send_cmd(ACT_READ, 0, 1, 1'b0);
    send_cmd(ACT_READ, 31, 31, 1'b0);
    send_cmd(ACT_WRITE, 11, 5, 1'b0);
    send_cmd(ACT_READ, 11, 5, 1'b0);
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
      send_cmd(action_t'(a), coord_t'($urandom), coord_t'($urandom), 1'($urandom));
    send_cmd(ACT_CLEAR, 0, 0, 1'b0);
    send_cmd(ACT_READ, 0, 0, 1'b0);
    send_cmd(ACT_READ, 31, 0, 1'b0);

    // Random part: seed a patch, let it evolve, then read it back.
    phase = 0;
    while (words_sent < ITEMS) begin
      phase++;
      last_sent = words_sent;
      src_idle = !(words_sent >= 400 && words_sent < 600);
      snk_idle = src_idle;
      if (phase == 4) hold_req = 1'b1;
      base_c = $urandom_range(MAX_COORD - 7);
      base_r = $urandom_range(MAX_COORD - 7);
      if ($urandom_range(3) == 0) send_cmd(ACT_CLEAR, coord_t'($urandom), 0, 1'b0);
      repeat ($urandom_range(10, 30))
        send_cmd(ACT_WRITE, near(base_c), near(base_r), $urandom_range(99) < 65);
      repeat ($urandom_range(1, 4))
        send_cmd(($urandom_range(4) == 0) ? ACT_SHIFT : ACT_GEN, 0, 0, 1'b0);
      repeat ($urandom_range(10, 25)) begin
        if ($urandom_range(5) == 0)
          send_cmd(ACT_READ, coord_t'($urandom), coord_t'($urandom), 1'($urandom));
        else
          send_cmd(ACT_READ, near(base_c), near(base_r), 1'b0);
      end
      // Noise: any code with any fields.
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 2))
          send_cmd(action_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                   1'($urandom));
      if (phase % 7 == 6) drain();
      if (words_sent == last_sent) break;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d command words with %0d generation steps; %0d reads found live cells.",
             words_sent, gen_count, live_reads);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
